>>> src/rrt_pkg.sv
// Shared package of the race result table: sizes, command and status codes,
// and the control and status words between controller and datapath. No dependencies.
package rrt_pkg;

	localparam int TABLE_ENTRIES = 32;
	localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

	localparam int CMD_W    = 2;
	localparam int KEY_W    = 16;
	localparam int TIME_W   = 32;
	localparam int STATUS_W = 2;
	localparam int MIN_W    = 17;
	localparam int SEC_W    = 6;
	localparam int MS_W     = 10;

	// elapsed-time split by reciprocal multiplication, q = (x * RECIP) >> SHIFT;
	// exact for every 32-bit time and for every whole-second count (23 bits)
	localparam int QSEC_W      = 23;
	localparam int RECIP_MS_W  = 29;
	localparam int RECIP_SEC_W = 24;
	localparam int SHIFT_MS    = 38;
	localparam int SHIFT_SEC   = 29;
	localparam int PROD_MS_W   = TIME_W + RECIP_MS_W;
	localparam int PROD_SEC_W  = QSEC_W + RECIP_SEC_W;

	localparam logic [RECIP_MS_W-1:0]  RECIP_MS    = 29'd274877907;
	localparam logic [RECIP_SEC_W-1:0] RECIP_SEC   = 24'd8947849;
	localparam logic [MS_W-1:0]        MS_PER_SEC  = 10'd1000;
	localparam logic [SEC_W-1:0]       SEC_PER_MIN = 6'd60;

	localparam logic [CMD_W-1:0] CMD_START  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_FINISH = 2'd1;
	localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd2;
	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

	localparam logic [STATUS_W-1:0] ST_VALID     = 2'd0;
	localparam logic [STATUS_W-1:0] ST_ORDER     = 2'd1;
	localparam logic [STATUS_W-1:0] ST_MISSING   = 2'd2;
	localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd3;

	typedef struct packed {
		logic load_item;
		logic scan_clear;
		logic scan_run;
		logic write_en;
		logic set_not_found;
		logic eval;
		logic div_step;
		logic div_next;
		logic div_fin;
		logic out_load;
	} rrt_ctl_t;

	typedef struct packed {
		logic [CMD_W-1:0] new_cmd;
		logic [CMD_W-1:0] item_cmd;
		logic             hit;
		logic             miss;
		logic             eval_ok;
		logic             out_free;
	} rrt_sts_t;

endpackage

>>> src/rrt_in_if.sv
// Input channel of the race result table: valid/ready and one command word.
// Depends on rrt_pkg.
interface rrt_in_if import rrt_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [CMD_W-1:0]  command;
	logic [KEY_W-1:0]  racer_id;
	logic [TIME_W-1:0] time_ms;

	modport source (output valid, command, racer_id, time_ms, input ready);
	modport sink   (input valid, command, racer_id, time_ms, output ready);
endinterface

>>> src/rrt_out_if.sv
// Result channel of the race result table: valid/ready and one result word.
// Depends on rrt_pkg.
interface rrt_out_if import rrt_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [KEY_W-1:0]    result_racer;
	logic [STATUS_W-1:0] status;
	logic [MIN_W-1:0]    minutes;
	logic [SEC_W-1:0]    seconds;
	logic [MS_W-1:0]     milliseconds;

	modport source (output valid, result_racer, status, minutes, seconds, milliseconds,
		input ready);
	modport sink   (input valid, result_racer, status, minutes, seconds, milliseconds,
		output ready);
endinterface

>>> src/rrt_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rrt_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                                         clk,
	input  logic                                         we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                             wr_data,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                             rd_data
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end
endmodule

>>> src/rrt_datapath.sv
// Datapath of the race result table: key/start/finish RAMs, scan counter,
// fill count and ring head, reciprocal time split and result register. Uses rrt_pkg, rrt_ram.
module rrt_datapath import rrt_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  rrt_ctl_t            ctl,
	output rrt_sts_t            sts,
	input  logic [CMD_W-1:0]    command,
	input  logic [KEY_W-1:0]    racer_id,
	input  logic [TIME_W-1:0]   time_ms,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [KEY_W-1:0]    result_racer,
	output logic [STATUS_W-1:0] status,
	output logic [MIN_W-1:0]    minutes,
	output logic [SEC_W-1:0]    seconds,
	output logic [MS_W-1:0]     milliseconds
);
	localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(TABLE_ENTRIES - 1);

	logic [CMD_W-1:0]    cmd_q;
	logic [KEY_W-1:0]    key_q;
	logic [TIME_W-1:0]   time_q;
	logic [CNT_W-1:0]    count_q;
	logic [IDX_W-1:0]    oldest_q;
	logic [CNT_W-1:0]    scan_idx_q;
	logic                pend_q;
	logic [IDX_W-1:0]    pidx_q;
	logic [IDX_W-1:0]    slot_q;
	logic                hit_q;
	logic [TIME_W-1:0]   div_q;
	logic [QSEC_W-1:0]   qsec_q;
	logic [MS_W-1:0]     ms_q;
	logic [MIN_W-1:0]    mins_q;
	logic [SEC_W-1:0]    secs_q;
	logic [STATUS_W-1:0] res_status_q;
	logic                out_valid_q;

	logic [IDX_W-1:0]    rd_addr;
	logic [KEY_W-1:0]    key_rd;
	logic [TIME_W-1:0]   start_rd;
	logic [TIME_W-1:0]   finish_rd;
	logic                issue;
	logic                hit;
	logic                miss;
	logic                full;
	logic                is_start;
	logic                start_we;
	logic                finish_we;
	logic [TIME_W-1:0]   start_wd;
	logic [TIME_W-1:0]   finish_wd;
	logic [PROD_MS_W-1:0]  prod_ms;
	logic [PROD_SEC_W-1:0] prod_sec;
	logic [MS_W-1:0]     ms_back;
	logic [SEC_W-1:0]    sec_back;
	logic [STATUS_W-1:0] eval_status;

	assign issue    = scan_idx_q < count_q;
	assign hit      = pend_q && (key_rd == key_q);
	assign miss     = !pend_q && !issue;
	assign full     = count_q == CNT_W'(TABLE_ENTRIES);
	assign rd_addr  = ctl.scan_run ? scan_idx_q[IDX_W-1:0] : slot_q;
	assign is_start = cmd_q == CMD_START;

	// a fresh entry gets both times written, the untouched one cleared
	assign start_we  = ctl.write_en && (is_start || !hit_q);
	assign finish_we = ctl.write_en && (!is_start || !hit_q);
	assign start_wd  = is_start ? time_q : '0;
	assign finish_wd = is_start ? '0 : time_q;

	rrt_ram #(.WIDTH(KEY_W), .DEPTH(TABLE_ENTRIES)) u_key_ram (
		.clk     (clk),
		.we      (ctl.write_en && !hit_q),
		.wr_addr (slot_q),
		.wr_data (key_q),
		.rd_addr (rd_addr),
		.rd_data (key_rd)
	);

	rrt_ram #(.WIDTH(TIME_W), .DEPTH(TABLE_ENTRIES)) u_start_ram (
		.clk     (clk),
		.we      (start_we),
		.wr_addr (slot_q),
		.wr_data (start_wd),
		.rd_addr (rd_addr),
		.rd_data (start_rd)
	);

	rrt_ram #(.WIDTH(TIME_W), .DEPTH(TABLE_ENTRIES)) u_finish_ram (
		.clk     (clk),
		.we      (finish_we),
		.wr_addr (slot_q),
		.wr_data (finish_wd),
		.rd_addr (rd_addr),
		.rd_data (finish_rd)
	);

	// hold the accepted word
	always_ff @(posedge clk) begin
		if (ctl.load_item) begin
			cmd_q  <= command;
			key_q  <= racer_id;
			time_q <= time_ms;
		end
	end

	// key scan: one read issued per cycle, compared in the cycle after
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_idx_q <= '0;
			pend_q     <= 1'b0;
			pidx_q     <= '0;
			slot_q     <= '0;
			hit_q      <= 1'b0;
			count_q    <= '0;
			oldest_q   <= '0;
		end else begin
			if (ctl.scan_clear) begin
				scan_idx_q <= '0;
				pend_q     <= 1'b0;
			end else if (ctl.scan_run) begin
				pend_q <= issue;
				pidx_q <= scan_idx_q[IDX_W-1:0];
				if (issue) begin
					scan_idx_q <= scan_idx_q + CNT_W'(1);
				end
				if (hit) begin
					slot_q <= pidx_q;
					hit_q  <= 1'b1;
				end else if (miss) begin
					slot_q <= full ? oldest_q : count_q[IDX_W-1:0];
					hit_q  <= 1'b0;
				end
			end
			if (ctl.write_en && !hit_q) begin
				if (!full) begin
					count_q <= count_q + CNT_W'(1);
				end else begin
					oldest_q <= (oldest_q == LAST_SLOT) ? '0 : oldest_q + IDX_W'(1);
				end
			end
		end
	end

	always_comb begin
		if (start_rd == '0 || finish_rd == '0) begin
			eval_status = ST_MISSING;
		end else if (start_rd >= finish_rd) begin
			eval_status = ST_ORDER;
		end else begin
			eval_status = ST_VALID;
		end
	end

	// split the elapsed time over three steps: whole seconds (32 by 29 bit
	// product), then milliseconds and minutes, then seconds; the remainders
	// only need their low bits, so subtract modulo the field width
	assign prod_ms  = PROD_MS_W'(div_q) * PROD_MS_W'(RECIP_MS);
	assign prod_sec = PROD_SEC_W'(qsec_q) * PROD_SEC_W'(RECIP_SEC);
	assign ms_back  = qsec_q[MS_W-1:0] * MS_PER_SEC;
	assign sec_back = mins_q[SEC_W-1:0] * SEC_PER_MIN;

	always_ff @(posedge clk) begin
		if (ctl.eval) begin
			res_status_q <= eval_status;
			div_q        <= finish_rd - start_rd;
		end else if (ctl.set_not_found) begin
			res_status_q <= ST_NOT_FOUND;
		end else if (ctl.div_step) begin
			qsec_q <= prod_ms[SHIFT_MS +: QSEC_W];
		end else if (ctl.div_next) begin
			ms_q   <= div_q[MS_W-1:0] - ms_back;
			mins_q <= prod_sec[SHIFT_SEC +: MIN_W];
		end else if (ctl.div_fin) begin
			secs_q <= qsec_q[SEC_W-1:0] - sec_back;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.out_load) begin
			result_racer <= key_q;
			status       <= res_status_q;
			if (res_status_q == ST_VALID) begin
				minutes      <= mins_q;
				seconds      <= secs_q;
				milliseconds <= ms_q;
			end else begin
				minutes      <= '0;
				seconds      <= '0;
				milliseconds <= '0;
			end
		end
	end

	assign out_valid = out_valid_q;

	assign sts.new_cmd  = command;
	assign sts.item_cmd = cmd_q;
	assign sts.hit      = hit;
	assign sts.miss     = miss;
	assign sts.eval_ok  = eval_status == ST_VALID;
	assign sts.out_free = !out_valid_q || out_ready;
endmodule

>>> src/rrt_controller.sv
// Sequencer of the race result table: steps one word through scan, store,
// read-back, division and result hand-over. Uses rrt_pkg.
module rrt_controller import rrt_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	output rrt_ctl_t ctl,
	input  rrt_sts_t sts
);
	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_SCAN   = 4'd1;
	localparam logic [3:0] S_WRITE  = 4'd2;
	localparam logic [3:0] S_READ   = 4'd3;
	localparam logic [3:0] S_EVAL   = 4'd4;
	localparam logic [3:0] S_DIV1   = 4'd5;
	localparam logic [3:0] S_DIVMID = 4'd6;
	localparam logic [3:0] S_DIV2   = 4'd7;
	localparam logic [3:0] S_OUT    = 4'd8;

	logic [3:0] state_q;
	logic [3:0] state_nx;

	assign in_ready = state_q == S_IDLE;

	always_comb begin
		ctl      = '0;
		state_nx = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					ctl.load_item = 1'b1;
					if (sts.new_cmd != CMD_UNUSED) begin
						ctl.scan_clear = 1'b1;
						state_nx       = S_SCAN;
					end
				end
			end
			S_SCAN: begin
				ctl.scan_run = 1'b1;
				if (sts.hit || sts.miss) begin
					if (sts.item_cmd != CMD_QUERY) begin
						state_nx = S_WRITE;
					end else if (sts.hit) begin
						state_nx = S_READ;
					end else begin
						ctl.set_not_found = 1'b1;
						state_nx          = S_OUT;
					end
				end
			end
			S_WRITE: begin
				ctl.write_en = 1'b1;
				state_nx     = (sts.item_cmd == CMD_START) ? S_IDLE : S_READ;
			end
			S_READ: begin
				state_nx = S_EVAL;
			end
			S_EVAL: begin
				ctl.eval = 1'b1;
				state_nx = sts.eval_ok ? S_DIV1 : S_OUT;
			end
			S_DIV1: begin
				ctl.div_step = 1'b1;
				state_nx     = S_DIVMID;
			end
			S_DIVMID: begin
				ctl.div_next = 1'b1;
				state_nx     = S_DIV2;
			end
			S_DIV2: begin
				ctl.div_fin = 1'b1;
				state_nx    = S_OUT;
			end
			S_OUT: begin
				if (sts.out_free) begin
					ctl.out_load = 1'b1;
					state_nx     = S_IDLE;
				end
			end
			default: begin
				state_nx = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end
endmodule

>>> src/race_result_table_unit.sv
// Race result table, top level: joins the controller and the datapath to the
// command and result channels. Uses rrt_pkg, rrt_in_if, rrt_out_if, rrt_controller, rrt_datapath.
//
// Keeps up to TABLE_ENTRIES racers, each with a start and a finish time in ms
// (0 means no data). A start or finish word updates the racer's entry, appends
// a new one, or, with the table full, overwrites the oldest entry in ring
// order. A finish word or a query word yields one result word: racer number,
// status (valid, start not before finish, time missing, racer not found) and
// the elapsed time split into minutes, seconds and milliseconds, zero unless
// the status is valid. Command code 3 is taken and dropped. Words are handled
// one at a time: the key scan reads one RAM entry per cycle, over the entries
// in use, and a finish word or a successful query then splits the elapsed
// time by reciprocal multiplication. A result word left waiting in the output
// register holds the controller at the hand-over of the next result, and with
// it the input. The table needs no clearing pass after reset: the fill count
// bounds every scan and fresh entries are written whole.
module race_result_table_unit import rrt_pkg::*; (
	input logic   clk,
	input logic   arst_n,
	rrt_in_if.sink    req,
	rrt_out_if.source rsp
);
	rrt_ctl_t ctl;
	rrt_sts_t sts;

	// sequence each word
	rrt_controller u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (req.ready),
		.ctl      (ctl),
		.sts      (sts)
	);

	// hold the table, split the elapsed time, drive the result word
	rrt_datapath u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctl          (ctl),
		.sts          (sts),
		.command      (req.command),
		.racer_id     (req.racer_id),
		.time_ms      (req.time_ms),
		.out_valid    (rsp.valid),
		.out_ready    (rsp.ready),
		.result_racer (rsp.result_racer),
		.status       (rsp.status),
		.minutes      (rsp.minutes),
		.seconds      (rsp.seconds),
		.milliseconds (rsp.milliseconds)
	);
endmodule

>>> sim/tb_race_result_table_unit.sv
// Self-checking bench for race_result_table_unit: a queue-fed driver, a checking monitor and
// a word-level table model that predicts every result word.
// Depends on rrt_pkg, rrt_in_if, rrt_out_if and the race_result_table_unit RTL.
module tb_race_result_table_unit;
	import rrt_pkg::*;

	typedef struct packed {
		logic [CMD_W-1:0]  cmd;
		logic [KEY_W-1:0]  racer;
		logic [TIME_W-1:0] stamp;
	} cmd_word_t;

	typedef struct packed {
		logic [KEY_W-1:0]    racer;
		logic [STATUS_W-1:0] status;
		logic [MIN_W-1:0]    mins;
		logic [SEC_W-1:0]    secs;
		logic [MS_W-1:0]     msecs;
	} result_word_t;

	localparam int RANDOM_WORDS = 1400;
	localparam int POOL_SIZE    = 44;
	localparam int HOLD_CYCLES  = 400;
	localparam int TAIL_CYCLES  = 200;

	logic clk;
	logic arst_n;

	rrt_in_if  req ();
	rrt_out_if rsp ();

	race_result_table_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	// Words waiting to be offered, and the result words the table model owes.
	cmd_word_t    word_q[$];
	result_word_t results_due[$];
	cmd_word_t    next_word;
	result_word_t seen_word;
	result_word_t due_word;

	// Model of the racer table; only slots below model_fill are ever read.
	logic [KEY_W-1:0]  model_key    [TABLE_ENTRIES];
	logic [TIME_W-1:0] model_start  [TABLE_ENTRIES];
	logic [TIME_W-1:0] model_finish [TABLE_ENTRIES];
	int                model_fill;
	int                model_head;

	int words_total;
	int words_sent;
	int results_checked;
	int evictions;
	int status_seen [4];
	int error_count;

	int tx_idle;
	int rx_idle;
	int hold_left;
	bit hold_done;

	// Clock.
	initial begin
		clk = 1'b0;
	end
	always #4 clk = ~clk;

	// Look up a racer among the slots in use; return TABLE_ENTRIES when absent.
	function automatic int lookup_slot(input logic [KEY_W-1:0] racer);
		int found;
		found = TABLE_ENTRIES;
		for (int i = model_fill - 1; i >= 0; i--) begin
			if (model_key[i] == racer)
				found = i;
		end
		return found;
	endfunction

	// Work out the result word for one racer from the model table.
	function automatic result_word_t elapsed_result(input logic [KEY_W-1:0] racer);
		result_word_t      r;
		int                slot;
		logic [TIME_W-1:0] diff;
		logic [TIME_W-1:0] whole_secs;
		r       = '0;
		r.racer = racer;
		slot    = lookup_slot(racer);
		if (slot == TABLE_ENTRIES) begin
			r.status = ST_NOT_FOUND;
		end else if (model_start[slot] == '0 || model_finish[slot] == '0) begin
			r.status = ST_MISSING;
		end else if (model_start[slot] >= model_finish[slot]) begin
			r.status = ST_ORDER;
		end else begin
			diff       = model_finish[slot] - model_start[slot];
			whole_secs = diff / 1000;
			r.status   = ST_VALID;
			r.msecs    = MS_W'(diff % 1000);
			r.secs     = SEC_W'(whole_secs % 60);
			r.mins     = MIN_W'(whole_secs / 60);
		end
		return r;
	endfunction

	// Store a start or finish time: update, append, or evict the oldest entry.
	task automatic store_stamp(input bit is_start, input logic [KEY_W-1:0] racer,
		input logic [TIME_W-1:0] stamp);
		int slot;
		slot = lookup_slot(racer);
		if (slot == TABLE_ENTRIES) begin
			if (model_fill < TABLE_ENTRIES) begin
				slot = model_fill;
				model_fill++;
			end else begin
				slot               = model_head;
				model_start[slot]  = '0;
				model_finish[slot] = '0;
				model_head         = (model_head + 1) % TABLE_ENTRIES;
				evictions++;
			end
			model_key[slot] = racer;
		end
		if (is_start)
			model_start[slot] = stamp;
		else
			model_finish[slot] = stamp;
	endtask

	// Advance the model by one accepted command word.
	task automatic advance_table(input cmd_word_t w);
		case (w.cmd)
			CMD_START: begin
				store_stamp(1'b1, w.racer, w.stamp);
			end
			CMD_FINISH: begin
				store_stamp(1'b0, w.racer, w.stamp);
				results_due.push_back(elapsed_result(w.racer));
			end
			CMD_QUERY: begin
				results_due.push_back(elapsed_result(w.racer));
			end
			default: begin
			end
		endcase
	endtask

	task automatic queue_word(input logic [CMD_W-1:0] cmd, input logic [KEY_W-1:0] racer,
		input logic [TIME_W-1:0] stamp);
		word_q.push_back({cmd, racer, stamp});
	endtask

	// Idling profile: follows how far the stimulus has got.
	always_comb begin
		if (words_sent < words_total / 3) begin
			tx_idle = 16;
			rx_idle = 68;
		end else if (words_sent < (2 * words_total) / 3) begin
			tx_idle = 68;
			rx_idle = 16;
		end else begin
			tx_idle = 0;
			rx_idle = 0;
		end
	end

	// Driver: retire the accepted word into the model, then offer the next one.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req.valid    <= 1'b0;
			req.command  <= '0;
			req.racer_id <= '0;
			req.time_ms  <= '0;
			words_sent   <= 0;
		end else begin
			if (req.valid && req.ready) begin
				advance_table({req.command, req.racer_id, req.time_ms});
				words_sent <= words_sent + 1;
			end
			if (!req.valid || req.ready) begin
				if (word_q.size() > 0 && $urandom_range(0, 99) >= tx_idle) begin
					next_word     = word_q.pop_front();
					req.valid    <= 1'b1;
					req.command  <= next_word.cmd;
					req.racer_id <= next_word.racer;
					req.time_ms  <= next_word.stamp;
				end else begin
					req.valid <= 1'b0;
				end
			end
		end
	end

	// Long hold-off of the receiver, once, late in the run: the sender keeps
	// offering words so that the block backs up and stalls its input.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
			hold_done <= 1'b0;
		end else if (!hold_done && words_total > 0 && words_sent >= (3 * words_total) / 4) begin
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
		end
	end

	// Monitor: check each accepted result word against the oldest prediction.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp.ready <= 1'b0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				seen_word = {rsp.result_racer, rsp.status, rsp.minutes, rsp.seconds,
					rsp.milliseconds};
				if (results_due.size() == 0) begin
					$display("%0t: unexpected result word racer %0d status %0d %0d:%0d.%0d",
						$time, seen_word.racer, seen_word.status, seen_word.mins,
						seen_word.secs, seen_word.msecs);
					error_count++;
				end else begin
					due_word = results_due.pop_front();
					results_checked++;
					status_seen[due_word.status]++;
					if (seen_word !== due_word) begin
						$display("%0t: result mismatch, expected racer %0d status %0d %0d:%0d.%0d, got racer %0d status %0d %0d:%0d.%0d",
							$time, due_word.racer, due_word.status, due_word.mins,
							due_word.secs, due_word.msecs, seen_word.racer, seen_word.status,
							seen_word.mins, seen_word.secs, seen_word.msecs);
						error_count++;
					end
				end
			end
			rsp.ready <= (hold_left == 0) && ($urandom_range(0, 99) >= rx_idle);
		end
	end

	// Stimulus and end of run.
	logic [KEY_W-1:0] racer_pool [POOL_SIZE];
	cmd_word_t        finish_q[$];

	initial begin
		int               roll;
		int               queued;
		int               pick;
		logic [KEY_W-1:0] racer;
		logic [TIME_W-1:0] stamp;
		logic [TIME_W-1:0] span;

		arst_n      = 1'b0;
		words_total = 0;

		// Directed: empty table, extremes of the fields, zero times, equal and
		// reversed times, the unused code and a query carrying a time.
		queue_word(CMD_QUERY,  16'h0000, 32'h0000_0000);
		queue_word(CMD_FINISH, 16'h0000, 32'h0000_0000);
		queue_word(CMD_START,  16'hFFFF, 32'hFFFF_FFFF);
		queue_word(CMD_FINISH, 16'hFFFF, 32'h0000_0001);
		queue_word(CMD_START,  16'hFFFF, 32'h0000_0001);
		queue_word(CMD_FINISH, 16'hFFFF, 32'hFFFF_FFFF);
		queue_word(CMD_START,  16'h5555, 32'h1234_5678);
		queue_word(CMD_FINISH, 16'h5555, 32'h1234_5678);
		queue_word(CMD_START,  16'hAAAA, 32'h0000_0000);
		queue_word(CMD_FINISH, 16'hAAAA, 32'd5000);
		queue_word(CMD_UNUSED, 16'h1234, 32'hA5A5_5A5A);
		queue_word(CMD_QUERY,  16'h1234, 32'h0000_0000);
		queue_word(CMD_QUERY,  16'hAAAA, 32'hFFFF_FFFF);
		queue_word(CMD_START,  16'hAAAA, 32'd1);
		queue_word(CMD_QUERY,  16'hAAAA, 32'h0000_0000);
		queue_word(CMD_START,  16'd7,    32'd1000);
		queue_word(CMD_FINISH, 16'd7,    32'd61001);
		queue_word(CMD_FINISH, 16'd7,    32'd60999);
		queue_word(CMD_QUERY,  16'h0000, 32'hFFFF_FFFF);

		// Random: mostly start/finish pairs over a pool a little larger than
		// the table, so the ring wraps often, with queries and noise between.
		for (int i = 0; i < POOL_SIZE; i++)
			racer_pool[i] = KEY_W'($urandom);
		queued = 0;
		while (queued < RANDOM_WORDS) begin
			roll = $urandom_range(0, 99);
			if (finish_q.size() > 6 || (roll >= 35 && roll < 70 && finish_q.size() > 0)) begin
				pick = ($urandom_range(0, 3) == 0) ? $urandom_range(0, finish_q.size() - 1) : 0;
				word_q.push_back(finish_q[pick]);
				finish_q.delete(pick);
			end else if (roll < 70) begin
				racer = racer_pool[$urandom_range(0, POOL_SIZE - 1)];
				stamp = ($urandom_range(0, 19) == 0) ? '0 : TIME_W'($urandom);
				span  = ($urandom_range(0, 9) == 0) ? TIME_W'($urandom)
					: TIME_W'($urandom_range(1, 7200000));
				queue_word(CMD_START, racer, stamp);
				finish_q.push_back({CMD_FINISH, racer, stamp + span});
			end else if (roll < 85) begin
				queue_word(CMD_QUERY, racer_pool[$urandom_range(0, POOL_SIZE - 1)],
					TIME_W'($urandom));
			end else begin
				queue_word(CMD_W'($urandom_range(0, 3)), KEY_W'($urandom), TIME_W'($urandom));
			end
			queued++;
		end
		while (finish_q.size() > 0)
			word_q.push_back(finish_q.pop_front());
		words_total = word_q.size();

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Drain: all words taken, all results in, then let the last word settle.
		while (word_q.size() > 0 || req.valid)
			@(posedge clk);
		while (results_due.size() > 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Run covered %0d command words and %0d result words, with %0d oldest-entry evictions.",
			words_sent, results_checked, evictions);
		$display("Statuses checked: valid %0d, order %0d, missing %0d, not found %0d.",
			status_seen[ST_VALID], status_seen[ST_ORDER], status_seen[ST_MISSING],
			status_seen[ST_NOT_FOUND]);
		if (error_count == 0) begin
			$display("race_result_table_unit test passed");
		end else begin
			$display("race_result_table_unit test failed");
		end
		$finish;
	end

	// Watchdog.
	initial begin
		#6000000;
		$display("race_result_table_unit test failed");
		$finish;
	end

endmodule
